// ===== rtl/twr_pkg.sv =====
package twr_pkg;

  // Configuration port geometry
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE_N = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_BYTES  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_K       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_N       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_K_BLOCKS     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_N_BLOCKS     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_N_REMAINDER  = 3'd6;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_INVALID  = 2'd1,
    ST_DONE     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_PLO,
    S_PHI,
    S_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic sum;
    logic plo;
    logic phi;
    logic cap_result;
    logic cap_invalid;
    logic cap_done;
  } dp_cmd_t;

  typedef struct packed {
    logic invalid;
    logic done;
  } dp_status_t;

endpackage

// ===== rtl/twr_channels.sv =====
interface twr_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface twr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_offset;
  logic [31:0] dst_index;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, output src_offset, output dst_index, output status,
                  output last, input ready);
  modport sink (input valid, input src_offset, input dst_index, input status,
                input last, output ready);
endinterface

// ===== rtl/twr_ctrl.sv =====
module twr_ctrl
  import twr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        out_free;
  logic        capture;

  assign out_free = !out_valid || out_ready;
  assign capture  = cmd.cap_result || cmd.cap_invalid || cmd.cap_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.invalid || status.done) begin
          if (out_free) state_next = S_IDLE;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_SUM;
      S_SUM:  state_next = S_PLO;
      S_PLO:  state_next = S_PHI;
      S_PHI:  state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == S_IDLE);
    cmd             = '0;
    cmd.accept      = (state == S_IDLE) && in_valid;
    cmd.mul1        = (state == S_MUL1);
    cmd.mul2        = (state == S_MUL2);
    cmd.sum         = (state == S_SUM);
    cmd.plo         = (state == S_PLO);
    cmd.phi         = (state == S_PHI);
    cmd.cap_result  = (state == S_FIN) && out_free;
    cmd.cap_invalid = (state == S_CHECK) && status.invalid && out_free;
    cmd.cap_done    = (state == S_CHECK) && !status.invalid && status.done && out_free;
  end

endmodule

// ===== rtl/twr_datapath.sv =====
module twr_datapath
  import twr_pkg::*;
#(
  parameter int ADDR_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  input  logic                   restart,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic [31:0]            src_offset,
  output logic [31:0]            dst_index,
  output status_t                res_status,
  output logic                   last
);

  localparam int CW    = COUNT_WIDTH;
  // Loop bounds are the registers cut to the counter width.
  localparam int BW    = (CW < CFG_WIDTH) ? CW : CFG_WIDTH;
  localparam int P1W   = CW + CFG_WIDTH;
  localparam int P2W   = CW + BW;
  localparam int P3W   = 2 * BW;
  localparam int P4W   = P3W + CFG_WIDTH;
  localparam int BASEW = ((P4W > P1W) ? P4W : P1W) + 2;
  localparam int HIW   = BASEW - 32;
  localparam int PLOW  = 32 + BW;
  localparam int PHIW  = HIW + BW;
  localparam int SUMW  = BASEW + BW + 1;
  localparam int CMPW  = (SUMW > ADDR_WIDTH + 1) ? SUMW : ADDR_WIDTH + 1;

  logic [CFG_WIDTH-1:0] row_stride_n, group_bytes, tile_k, tile_n;
  logic [CFG_WIDTH-1:0] k_blocks, n_blocks, n_remainder;

  logic [CW-1:0] n_block_ctr, k_block_ctr, row_ctr, col_ctr, byte_ctr;
  logic [31:0]   dest_ctr;
  logic          finished;

  logic [CW-1:0] n_block_ctr_next, k_block_ctr_next, row_ctr_next;
  logic [CW-1:0] col_ctr_next, byte_ctr_next;
  logic          wrapped;

  logic [BW-1:0] tk, tn, kb, nb, gb, rem, cols;

  logic [P1W-1:0]   p1;
  logic [P2W-1:0]   p2;
  logic [P3W-1:0]   p3;
  logic [P4W-1:0]   p4;
  logic [BASEW-1:0] s12, base;
  logic [PLOW-1:0]  plo;
  logic [PHIW-1:0]  phi;
  logic [SUMW-1:0]  addr_sum;
  logic [CMPW-1:0]  addr_cmp;
  logic             ovf;

  assign tk  = BW'(tile_k);
  assign tn  = BW'(tile_n);
  assign kb  = BW'(k_blocks);
  assign nb  = BW'(n_blocks);
  assign gb  = BW'(group_bytes);
  assign rem = BW'(n_remainder);

  assign status.invalid = (tk == '0) || (tn == '0);
  assign status.done    = finished || (nb == '0) || (kb == '0) || (gb == '0) ||
                          (n_block_ctr >= CW'(nb)) || (k_block_ctr >= CW'(kb));

  // The last N block uses the remainder as its width when a remainder is set.
  assign cols = ((n_block_ctr == CW'(nb - BW'(1))) && (rem != '0)) ? rem : tn;

  assign addr_sum = SUMW'(plo) + (SUMW'(phi) << 32) + SUMW'(byte_ctr);
  assign addr_cmp = CMPW'(addr_sum);
  assign ovf      = |(addr_cmp >> ADDR_WIDTH);

  // Nested wrap of the loop counters, innermost first.
  always_comb begin
    n_block_ctr_next = n_block_ctr;
    k_block_ctr_next = k_block_ctr;
    row_ctr_next     = row_ctr;
    col_ctr_next     = col_ctr;
    byte_ctr_next    = byte_ctr + CW'(1);
    wrapped          = 1'b0;
    if (byte_ctr_next >= CW'(gb) || byte_ctr_next == '0) begin
      byte_ctr_next = '0;
      col_ctr_next  = col_ctr + CW'(1);
      if (col_ctr_next >= CW'(cols) || col_ctr_next == '0) begin
        col_ctr_next = '0;
        row_ctr_next = row_ctr + CW'(1);
        if (row_ctr_next >= CW'(tk) || row_ctr_next == '0) begin
          row_ctr_next     = '0;
          k_block_ctr_next = k_block_ctr + CW'(1);
          if (k_block_ctr_next >= CW'(kb) || k_block_ctr_next == '0) begin
            k_block_ctr_next = '0;
            n_block_ctr_next = n_block_ctr + CW'(1);
            if (n_block_ctr_next >= CW'(nb) || n_block_ctr_next == '0) begin
              n_block_ctr_next = '0;
              wrapped          = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride_n <= CFG_WIDTH'(1);
      group_bytes  <= CFG_WIDTH'(1);
      tile_k       <= CFG_WIDTH'(1);
      tile_n       <= CFG_WIDTH'(1);
      k_blocks     <= '0;
      n_blocks     <= '0;
      n_remainder  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_STRIDE_N: row_stride_n <= cfg_data;
        REG_GROUP_BYTES:  group_bytes  <= cfg_data;
        REG_TILE_K:       tile_k       <= cfg_data;
        REG_TILE_N:       tile_n       <= cfg_data;
        REG_K_BLOCKS:     k_blocks     <= cfg_data;
        REG_N_BLOCKS:     n_blocks     <= cfg_data;
        REG_N_REMAINDER:  n_remainder  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.accept && restart)) begin
      n_block_ctr <= '0;
      k_block_ctr <= '0;
      row_ctr     <= '0;
      col_ctr     <= '0;
      byte_ctr    <= '0;
      dest_ctr    <= '0;
      finished    <= 1'b0;
    end else if (cmd.cap_result) begin
      n_block_ctr <= n_block_ctr_next;
      k_block_ctr <= k_block_ctr_next;
      row_ctr     <= row_ctr_next;
      col_ctr     <= col_ctr_next;
      byte_ctr    <= byte_ctr_next;
      dest_ctr    <= dest_ctr + 32'd1;
      if (wrapped) finished <= 1'b1;
    end else if (cmd.cap_done) begin
      finished <= 1'b1;
    end
  end

  // Source offset arithmetic, one multiplier deep per cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p1 <= P1W'(row_ctr) * P1W'(row_stride_n);
      p2 <= P2W'(n_block_ctr) * P2W'(tn);
      // The K block counter is below its bound here, so BW bits hold it.
      p3 <= P3W'(k_block_ctr[BW-1:0]) * P3W'(tk);
    end
    if (cmd.mul2) begin
      p4  <= P4W'(p3) * P4W'(row_stride_n);
      s12 <= BASEW'(col_ctr) + BASEW'(p1) + BASEW'(p2);
    end
    if (cmd.sum) begin
      base <= s12 + BASEW'(p4);
    end
    if (cmd.plo) begin
      plo <= PLOW'(base[31:0]) * PLOW'(gb);
    end
    if (cmd.phi) begin
      phi <= PHIW'(base[BASEW-1:32]) * PHIW'(gb);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_result) begin
      src_offset <= ovf ? 32'd0 : addr_sum[31:0];
      dst_index  <= dest_ctr;
      res_status <= ovf ? ST_OVERFLOW : ST_VALID;
      last       <= wrapped;
    end else if (cmd.cap_invalid || cmd.cap_done) begin
      src_offset <= '0;
      dst_index  <= '0;
      res_status <= cmd.cap_invalid ? ST_INVALID : ST_DONE;
      last       <= 1'b0;
    end
  end

endmodule

// ===== rtl/tiled_weight_reorder_address_gen_top.sv =====
// A taken request is checked; a valid or overflow address then passes the states MUL1,
// MUL2, SUM, PLO, PHI and FIN and is registered from FIN; an invalid or done status
// from CHECK. Captures wait for a free response slot. The source offset uses one
// shared multiply and add sequence, so no new request is taken until capture.
// Reset (rst, synchronous, active high) restores the register defaults and clears all
// loop counters, the destination count and the finished flag.
module tiled_weight_reorder_address_gen_top
  import twr_pkg::*;
#(
  parameter int ADDR_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  twr_req_if.sink                req,
  twr_rsp_if.source              rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;
  status_t    res_status;

  twr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .status    (status),
    .cmd       (cmd)
  );

  twr_datapath #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .restart    (req.restart),
    .cmd        (cmd),
    .status     (status),
    .src_offset (rsp.src_offset),
    .dst_index  (rsp.dst_index),
    .res_status (res_status),
    .last       (rsp.last)
  );

  assign rsp.status = res_status;

endmodule
